### hw/rtl/lcdws_pkg.sv
// Shared types and constants for the 4-bit character LCD write sequencer.
package lcdws_pkg;

   // microcode address width and fixed program entry points
   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] ENTRY_INIT = 5'd0;
   localparam logic [UPC_W-1:0] ENTRY_BYTE = 5'd25;
   localparam logic [UPC_W-1:0] UPC_LAST   = 5'd28;

   // request kinds
   localparam logic [1:0] KIND_INIT   = 2'd0;
   localparam logic [1:0] KIND_BYTE   = 2'd1;
   localparam logic [1:0] KIND_CURSOR = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_ENABLE_PULSE = 2'd0;
   localparam logic [1:0] CSR_BYTE_GAP     = 2'd1;
   localparam logic [1:0] CSR_INIT_GAP     = 2'd2;
   localparam logic [1:0] CSR_POWER_UP     = 2'd3;

   // set-DDRAM-address command bases
   localparam logic [7:0] CURSOR_ROW0 = 8'h80;
   localparam logic [7:0] CURSOR_ROW1 = 8'hC0;

   localparam int HOLD_W = 10;

   typedef enum logic [1:0] {
      NIB_CONST,
      NIB_HI,
      NIB_LO
   } nib_sel_type;

   typedef enum logic [2:0] {
      HOLD_POWER,
      HOLD_PULSE,
      HOLD_PULSE_INIT,
      HOLD_PULSE_GAP,
      HOLD_PULSE_GAP_INIT
   } hold_sel_type;

   typedef enum logic {
      SEQ_NEXT,
      SEQ_END
   } seq_op_type;

   typedef struct packed {
      nib_sel_type  nib_sel;
      logic [3:0]   nib_const;
      logic         en;
      hold_sel_type hold_sel;
      seq_op_type   seq;
   } ctrl_type;

   typedef struct packed {
      logic [7:0] enable_pulse_ms;
      logic [7:0] byte_gap_ms;
      logic [7:0] init_gap_ms;
      logic [7:0] power_up_ms;
   } cfg_type;

   typedef struct packed {
      logic              rs;
      logic              en;
      logic [3:0]        nibble;
      logic [HOLD_W-1:0] hold_ms;
      logic              last;
   } pin_state_type;

endpackage

### hw/rtl/lcdws_ucode_rom.sv
// Microcode ROM: one control word per sequencer step.
module lcdws_ucode_rom (
   input  logic [lcdws_pkg::UPC_W-1:0] upc,
   output lcdws_pkg::ctrl_type         ctrl
);

   function automatic lcdws_pkg::ctrl_type mk(
      input lcdws_pkg::nib_sel_type  sel,
      input logic [3:0]              nib,
      input logic                    en,
      input lcdws_pkg::hold_sel_type hold,
      input lcdws_pkg::seq_op_type   seq
   );
      lcdws_pkg::ctrl_type w;
      w.nib_sel   = sel;
      w.nib_const = nib;
      w.en        = en;
      w.hold_sel  = hold;
      w.seq       = seq;
      return w;
   endfunction

   always_comb begin
      unique case (upc)
         // init: power-up wait
         5'd0:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b0, lcdws_pkg::HOLD_POWER,
                          lcdws_pkg::SEQ_NEXT);
         // three wake-up nibbles
         5'd1:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h3, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd2:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h3, 1'b0, lcdws_pkg::HOLD_PULSE_INIT,
                          lcdws_pkg::SEQ_NEXT);
         5'd3:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h3, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd4:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h3, 1'b0, lcdws_pkg::HOLD_PULSE_INIT,
                          lcdws_pkg::SEQ_NEXT);
         5'd5:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h3, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd6:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h3, 1'b0, lcdws_pkg::HOLD_PULSE_INIT,
                          lcdws_pkg::SEQ_NEXT);
         // switch to 4-bit mode
         5'd7:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h2, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd8:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h2, 1'b0, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         // function set 0x28
         5'd9:  ctrl = mk(lcdws_pkg::NIB_CONST, 4'h2, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd10: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h2, 1'b0, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd11: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h8, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd12: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h8, 1'b0, lcdws_pkg::HOLD_PULSE_GAP,
                          lcdws_pkg::SEQ_NEXT);
         // display on 0x0C
         5'd13: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd14: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b0, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd15: ctrl = mk(lcdws_pkg::NIB_CONST, 4'hC, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd16: ctrl = mk(lcdws_pkg::NIB_CONST, 4'hC, 1'b0, lcdws_pkg::HOLD_PULSE_GAP,
                          lcdws_pkg::SEQ_NEXT);
         // entry mode 0x06
         5'd17: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd18: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b0, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd19: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h6, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd20: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h6, 1'b0, lcdws_pkg::HOLD_PULSE_GAP,
                          lcdws_pkg::SEQ_NEXT);
         // clear 0x01, extra init gap at the end
         5'd21: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd22: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b0, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd23: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h1, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd24: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h1, 1'b0,
                          lcdws_pkg::HOLD_PULSE_GAP_INIT, lcdws_pkg::SEQ_END);
         // latched byte routine (send byte, set cursor)
         5'd25: ctrl = mk(lcdws_pkg::NIB_HI, 4'h0, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd26: ctrl = mk(lcdws_pkg::NIB_HI, 4'h0, 1'b0, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd27: ctrl = mk(lcdws_pkg::NIB_LO, 4'h0, 1'b1, lcdws_pkg::HOLD_PULSE,
                          lcdws_pkg::SEQ_NEXT);
         5'd28: ctrl = mk(lcdws_pkg::NIB_LO, 4'h0, 1'b0, lcdws_pkg::HOLD_PULSE_GAP,
                          lcdws_pkg::SEQ_END);
         default: ctrl = mk(lcdws_pkg::NIB_CONST, 4'h0, 1'b0, lcdws_pkg::HOLD_PULSE,
                            lcdws_pkg::SEQ_END);
      endcase
   end

endmodule

### hw/rtl/lcdws_datapath.sv
// Datapath: turns a control word, the latched byte and the timing registers into a pin state.
module lcdws_datapath (
   input  lcdws_pkg::ctrl_type      ctrl,
   input  logic [7:0]               byte_val,
   input  logic                     rs,
   input  lcdws_pkg::cfg_type       cfg,
   output lcdws_pkg::pin_state_type pin
);

   logic [lcdws_pkg::HOLD_W-1:0] pulse;
   logic [lcdws_pkg::HOLD_W-1:0] gap;
   logic [lcdws_pkg::HOLD_W-1:0] init_gap;
   logic [lcdws_pkg::HOLD_W-1:0] power;

   assign pulse    = {2'b00, cfg.enable_pulse_ms};
   assign gap      = {2'b00, cfg.byte_gap_ms};
   assign init_gap = {2'b00, cfg.init_gap_ms};
   assign power    = {2'b00, cfg.power_up_ms};

   always_comb begin
      pin.rs   = rs;
      pin.en   = ctrl.en;
      pin.last = (ctrl.seq == lcdws_pkg::SEQ_END);

      unique case (ctrl.nib_sel)
         lcdws_pkg::NIB_HI: pin.nibble = byte_val[7:4];
         lcdws_pkg::NIB_LO: pin.nibble = byte_val[3:0];
         default:           pin.nibble = ctrl.nib_const;
      endcase

      // max sum 3*255 fits in 10 bits
      unique case (ctrl.hold_sel)
         lcdws_pkg::HOLD_POWER:          pin.hold_ms = power;
         lcdws_pkg::HOLD_PULSE_INIT:     pin.hold_ms = pulse + init_gap;
         lcdws_pkg::HOLD_PULSE_GAP:      pin.hold_ms = pulse + gap;
         lcdws_pkg::HOLD_PULSE_GAP_INIT: pin.hold_ms = pulse + gap + init_gap;
         default:                        pin.hold_ms = pulse;
      endcase
   end

endmodule

### hw/rtl/lcd_4bit_write_sequencer.sv
// Top level: microcode sequencer, request latch, timing registers and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  kind, value, is_data, row, col
//   rsp      out        rsp_valid / rsp_stall  rs, en, nibble, hold_ms, last
//   csr      in         csr_valid / csr_ready  index, data (timing registers)
//
// The step counter walks the microcode ROM one word per cycle, one pin state per word:
// init runs 25 steps, send byte and set cursor 4. A request is taken while no program
// runs, so a new request waits until the running program has ended; kind 3 is taken
// but yields nothing. The step counter only advances when the result register is free
// or being taken, so rsp_stall stalls the program in place. Synchronous reset loads the
// timing register defaults and empties the sequencer and result register.
module lcd_4bit_write_sequencer #(
   parameter int COLUMNS = 40
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_value,
   input  logic        req_is_data,
   input  logic        req_row,
   input  logic [5:0]  req_col,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rs,
   output logic        rsp_en,
   output logic [3:0]  rsp_nibble,
   output logic [9:0]  rsp_hold_ms,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam logic [5:0] COL_MAX = 6'(COLUMNS - 1);

   lcdws_pkg::cfg_type            cfg_ff;
   logic                          busy_ff, busy_in;
   logic [lcdws_pkg::UPC_W-1:0]   upc_ff, upc_in;
   logic [7:0]                    byte_ff;
   logic                          rs_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   lcdws_pkg::pin_state_type      rsp_data_ff;

   lcdws_pkg::ctrl_type           ctrl;
   lcdws_pkg::pin_state_type      pin;
   logic                          accept;
   logic                          load;
   logic [5:0]                    col_sat;
   logic [7:0]                    req_byte;

   lcdws_ucode_rom u_rom (
      .upc  (upc_ff),
      .ctrl (ctrl)
   );

   lcdws_datapath u_dp (
      .ctrl     (ctrl),
      .byte_val (byte_ff),
      .rs       (rs_ff),
      .cfg      (cfg_ff),
      .pin      (pin)
   );

   assign csr_ready = 1'b1;
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign load      = busy_ff && (!rsp_valid_ff || !rsp_stall);

   // byte to send: value for send byte, address command for set cursor
   always_comb begin
      col_sat = (req_col > COL_MAX) ? COL_MAX : req_col;
      case (req_kind)
         lcdws_pkg::KIND_CURSOR:
            req_byte = (req_row ? lcdws_pkg::CURSOR_ROW1 : lcdws_pkg::CURSOR_ROW0)
                       + {2'b00, col_sat};
         default:
            req_byte = req_value;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         upc_in       = upc_ff + 5'd1;
         if (ctrl.seq == lcdws_pkg::SEQ_END) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = (req_kind != lcdws_pkg::KIND_NONE);
         upc_in  = (req_kind == lcdws_pkg::KIND_INIT) ? lcdws_pkg::ENTRY_INIT
                                                      : lcdws_pkg::ENTRY_BYTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= lcdws_pkg::ENTRY_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_ms <= 8'd1;
         cfg_ff.byte_gap_ms     <= 8'd2;
         cfg_ff.init_gap_ms     <= 8'd5;
         cfg_ff.power_up_ms     <= 8'd20;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcdws_pkg::CSR_ENABLE_PULSE: cfg_ff.enable_pulse_ms <= csr_data;
            lcdws_pkg::CSR_BYTE_GAP:     cfg_ff.byte_gap_ms     <= csr_data;
            lcdws_pkg::CSR_INIT_GAP:     cfg_ff.init_gap_ms     <= csr_data;
            default:                     cfg_ff.power_up_ms     <= csr_data;
         endcase
      end
   end

   // request latch and result register: payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_byte;
         rs_ff   <= (req_kind == lcdws_pkg::KIND_BYTE) ? req_is_data : 1'b0;
      end
      if (load) begin
         rsp_data_ff <= pin;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_rs      = rsp_data_ff.rs;
   assign rsp_en      = rsp_data_ff.en;
   assign rsp_nibble  = rsp_data_ff.nibble;
   assign rsp_hold_ms = rsp_data_ff.hold_ms;
   assign rsp_last    = rsp_data_ff.last;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind != lcdws_pkg::KIND_NONE) |=> busy_ff)
      else $error("accepted request did not start a program");

   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (upc_ff <= lcdws_pkg::UPC_LAST))
      else $error("step counter ran past the microcode");

   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      (load && ctrl.seq == lcdws_pkg::SEQ_END) |=> (!busy_ff && rsp_valid_ff && rsp_last))
      else $error("end of program did not stop the sequencer");

   a_last_en_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !rsp_en)
      else $error("run ended with enable high");

endmodule
